[hw/rtl/dds_pkg.sv]
package dds_pkg;

  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int PHASE_WIDTH_DEF = 32;

  localparam int INDEX_WIDTH     = 12;
  localparam int WORD_WIDTH      = 16;
  localparam int CODE_WIDTH      = 12;
  localparam int AMP_WIDTH       = 14;
  localparam int CFG_DATA_WIDTH  = 32;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [WORD_WIDTH-1:0] DAC_CMD  = 16'h3000;
  localparam logic [CODE_WIDTH-1:0] CODE_MAX = 12'hFFF;

  // Signed working width for gains, levels and scaled ramp values.
  localparam int CALC_WIDTH = 27;
  typedef logic signed [CALC_WIDTH-1:0] calc_t;

  localparam calc_t GAIN_POS    = 27'sd1911;
  localparam calc_t GAIN_NEG    = 27'sd1907;
  localparam calc_t DC_BASE_POS = 27'sd10350000;
  localparam calc_t DC_BASE_NEG = 27'sd10345000;

  // Floor division by 5000: bias the dividend positive by 5000 * DIV_BIAS,
  // drop three bits, then multiply by the rounded-up reciprocal of 625.
  localparam int    DIV_BIAS    = 4096;
  localparam calc_t DIV_OFFSET  = 27'sd20480000;
  localparam int    DIV_SHIFT   = 3;
  localparam int    QUOT_WIDTH  = 23;
  localparam int    RECIP_WIDTH = 24;
  localparam logic [RECIP_WIDTH-1:0] RECIP = 24'd13743896;
  localparam int    RECIP_SHIFT = 33;
  localparam int    Q_WIDTH     = 14;
  typedef logic [QUOT_WIDTH-1:0] div_in_t;

  localparam int SAW_BASE = 2070;
  localparam logic signed [15:0] SAW_ADJ = 16'(DIV_BIAS - SAW_BASE);
  localparam logic signed [15:0] DC_ADJ  = 16'(DIV_BIAS);

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    MODE_TABLE = 2'd0,
    MODE_SAW   = 2'd1,
    MODE_DC    = 2'd2
  } wave_mode_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_TUNING    = 2'd0,
    CFG_MODE      = 2'd1,
    CFG_AMPLITUDE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic tick;
    logic write;
    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic en5;
  } pipe_ctrl_t;

endpackage

[hw/rtl/dds_ram.sv]
module dds_ram #(
  parameter int WIDTH = dds_pkg::WORD_WIDTH,
  parameter int DEPTH = dds_pkg::TABLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/dds_ctrl.sv]
module dds_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                op,
  input  logic                dac_ready,
  output logic                item_ready,
  output logic                dac_valid,
  output dds_pkg::pipe_ctrl_t ctrl
);

  logic s1_valid;
  logic s2_valid;
  logic s3_valid;
  logic s4_valid;
  logic s5_valid;
  logic accept;

  // A stage loads when it is empty or its contents move on.
  always_comb begin
    ctrl.en5   = !s5_valid || dac_ready;
    ctrl.en4   = !s4_valid || ctrl.en5;
    ctrl.en3   = !s3_valid || ctrl.en4;
    ctrl.en2   = !s2_valid || ctrl.en3;
    ctrl.en1   = !s1_valid || ctrl.en2;
    accept     = item_valid && ctrl.en1;
    ctrl.tick  = accept && (op == dds_pkg::OP_TICK);
    ctrl.write = accept && (op == dds_pkg::OP_WRITE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      if (ctrl.en1) begin
        s1_valid <= ctrl.tick;
      end
      if (ctrl.en2) begin
        s2_valid <= s1_valid;
      end
      if (ctrl.en3) begin
        s3_valid <= s2_valid;
      end
      if (ctrl.en4) begin
        s4_valid <= s3_valid;
      end
      if (ctrl.en5) begin
        s5_valid <= s4_valid;
      end
    end
  end

  assign item_ready = ctrl.en1;
  assign dac_valid  = s5_valid;

endmodule

[hw/rtl/dds_code.sv]
module dds_code #(
  parameter int ADDR_W = $clog2(dds_pkg::TABLE_DEPTH_DEF)
) (
  input  logic                              clk,
  input  dds_pkg::pipe_ctrl_t               ctrl,
  input  logic [1:0]                        wave_mode,
  input  dds_pkg::calc_t                    saw_gain,
  input  dds_pkg::div_in_t                  dc_level,
  input  logic [ADDR_W-1:0]                 phase_idx,
  input  logic [dds_pkg::WORD_WIDTH-1:0]    table_data,
  output logic [dds_pkg::WORD_WIDTH-1:0]    dac_word
);

  localparam int PROD_W = dds_pkg::CALC_WIDTH + ADDR_W + 1;
  localparam int RP_W   = dds_pkg::QUOT_WIDTH + dds_pkg::RECIP_WIDTH;

  logic [ADDR_W-1:0]                 idx1;
  logic signed [PROD_W-1:0]          ramp2;
  logic [dds_pkg::CODE_WIDTH-1:0]    tcode2;
  dds_pkg::calc_t                    ramp_scaled;
  dds_pkg::calc_t                    ramp_biased;
  dds_pkg::div_in_t                  div_in3;
  logic [dds_pkg::CODE_WIDTH-1:0]    tcode3;
  logic [RP_W-1:0]                   recip_prod;
  logic [dds_pkg::Q_WIDTH-1:0]       quot4;
  logic [dds_pkg::CODE_WIDTH-1:0]    tcode4;
  logic signed [15:0]                level;
  logic [dds_pkg::CODE_WIDTH-1:0]    level_code;
  logic [dds_pkg::CODE_WIDTH-1:0]    code;

  always_ff @(posedge clk) begin
    if (ctrl.en1) begin
      idx1 <= phase_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en2) begin
      ramp2  <= saw_gain * $signed({1'b0, idx1});
      tcode2 <= table_data[dds_pkg::CODE_WIDTH-1:0];
    end
  end

  // Arithmetic shift by the index width is the floor division by the depth.
  always_comb begin
    ramp_scaled = dds_pkg::calc_t'(ramp2 >>> ADDR_W);
    ramp_biased = ramp_scaled + dds_pkg::DIV_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (ctrl.en3) begin
      if (wave_mode == dds_pkg::MODE_SAW) begin
        div_in3 <= ramp_biased[dds_pkg::DIV_SHIFT +: dds_pkg::QUOT_WIDTH];
      end else begin
        div_in3 <= dc_level;
      end
      tcode3 <= tcode2;
    end
  end

  assign recip_prod = RP_W'(div_in3) * RP_W'(dds_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (ctrl.en4) begin
      quot4  <= recip_prod[dds_pkg::RECIP_SHIFT +: dds_pkg::Q_WIDTH];
      tcode4 <= tcode3;
    end
  end

  always_comb begin
    if (wave_mode == dds_pkg::MODE_SAW) begin
      level = $signed(16'(quot4)) - dds_pkg::SAW_ADJ;
    end else begin
      level = $signed(16'(quot4)) - dds_pkg::DC_ADJ;
    end
    if (level < 16'sd0) begin
      level_code = '0;
    end else if (level > $signed({4'b0, dds_pkg::CODE_MAX})) begin
      level_code = dds_pkg::CODE_MAX;
    end else begin
      level_code = level[dds_pkg::CODE_WIDTH-1:0];
    end
    unique case (wave_mode)
      dds_pkg::MODE_SAW: code = level_code;
      dds_pkg::MODE_DC:  code = level_code;
      default:           code = tcode4;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.en5) begin
      dac_word <= dds_pkg::DAC_CMD | {4'b0, code};
    end
  end

endmodule

[hw/rtl/dds_waveform_generator_core.sv]
// Direct digital synthesizer for a 12-bit SPI DAC. A tick transaction adds the
// tuning word to the phase accumulator and yields one DAC word, 0x3000 plus a
// 12-bit code taken from the waveform table, a sawtooth ramp or a DC level; a
// write transaction stores one table word and yields nothing. One transaction
// is taken each cycle unless the output stalls; a tick's result is registered
// in idx1, ramp2, div_in3, quot4 and dac_word. The phase add and the table read
// happen in the accept cycle, so the single-port-per-direction table RAM sets
// the rate of one per cycle. A stalled output fills the internal stages before
// input ready drops. The table holds TABLE_DEPTH entries, which must be a power
// of two, and reads of unwritten entries return undefined data. Registers must
// be written only while no transaction is in flight; the block does not check.
module dds_waveform_generator_core #(
  parameter int TABLE_DEPTH = dds_pkg::TABLE_DEPTH_DEF,
  parameter int PHASE_WIDTH = dds_pkg::PHASE_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_ready,
  input  logic                                  op,
  input  logic [dds_pkg::INDEX_WIDTH-1:0]       table_index,
  input  logic [dds_pkg::WORD_WIDTH-1:0]        table_word,
  output logic                                  dac_valid,
  input  logic                                  dac_ready,
  output logic [dds_pkg::WORD_WIDTH-1:0]        dac_word,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dds_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [dds_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  dds_pkg::pipe_ctrl_t                  ctrl;
  logic [dds_pkg::CFG_DATA_WIDTH-1:0]   tuning_word;
  logic [1:0]                           wave_mode;
  dds_pkg::calc_t                       saw_gain;
  dds_pkg::div_in_t                     dc_level;
  logic signed [dds_pkg::AMP_WIDTH-1:0] cfg_mv;
  dds_pkg::calc_t                       cfg_mv_ext;
  logic [PHASE_WIDTH-1:0]               phase;
  logic [PHASE_WIDTH-1:0]               phase_next;
  logic [ADDR_W-1:0]                    phase_idx;
  logic                                 ram_we;
  logic [dds_pkg::WORD_WIDTH-1:0]       ram_rdata;

  function automatic dds_pkg::div_in_t dc_div_in(input logic signed [13:0] mv);
    dds_pkg::calc_t mv_ext;
    dds_pkg::calc_t num;
    dds_pkg::calc_t biased;
    mv_ext = dds_pkg::calc_t'(mv);
    if (mv < 14'sd0) begin
      num = dds_pkg::DC_BASE_NEG - mv_ext * dds_pkg::GAIN_NEG;
    end else begin
      num = dds_pkg::DC_BASE_POS - mv_ext * dds_pkg::GAIN_POS;
    end
    biased = num + dds_pkg::DIV_OFFSET;
    return biased[dds_pkg::DIV_SHIFT +: dds_pkg::QUOT_WIDTH];
  endfunction

  assign cfg_ready  = 1'b1;
  assign cfg_mv     = cfg_data[dds_pkg::AMP_WIDTH-1:0];
  assign cfg_mv_ext = dds_pkg::calc_t'(cfg_mv);

  // The amplitude is stored as the negated ramp gain and the biased DC level.
  always_ff @(posedge clk) begin
    if (rst) begin
      tuning_word <= '0;
      wave_mode   <= dds_pkg::MODE_TABLE;
      saw_gain    <= '0;
      dc_level    <= dc_div_in(14'sd0);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dds_pkg::CFG_TUNING: tuning_word <= cfg_data;
        dds_pkg::CFG_MODE:   wave_mode   <= cfg_data[1:0];
        dds_pkg::CFG_AMPLITUDE: begin
          saw_gain <= -(cfg_mv_ext * dds_pkg::GAIN_POS);
          dc_level <= dc_div_in(cfg_mv);
        end
        default: ;
      endcase
    end
  end

  assign phase_next = phase + PHASE_WIDTH'(tuning_word);
  assign phase_idx  = phase_next[PHASE_WIDTH-1 -: ADDR_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (ctrl.tick) begin
      phase <= phase_next;
    end
  end

  assign ram_we = ctrl.write && (32'(table_index) < 32'(TABLE_DEPTH));

  dds_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .op         (op),
    .dac_ready  (dac_ready),
    .item_ready (item_ready),
    .dac_valid  (dac_valid),
    .ctrl       (ctrl)
  );

  dds_ram #(
    .WIDTH (dds_pkg::WORD_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(table_index)),
    .wdata (table_word),
    .re    (ctrl.tick),
    .raddr (phase_idx),
    .rdata (ram_rdata)
  );

  dds_code #(
    .ADDR_W (ADDR_W)
  ) u_code (
    .clk        (clk),
    .ctrl       (ctrl),
    .wave_mode  (wave_mode),
    .saw_gain   (saw_gain),
    .dc_level   (dc_level),
    .phase_idx  (phase_idx),
    .table_data (ram_rdata),
    .dac_word   (dac_word)
  );

  a_phase_step: assert property (@(posedge clk) disable iff (rst)
    ctrl.tick |=> phase == $past(phase_next))
    else $error("phase did not advance by the tuning word");

  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !ctrl.tick |=> $stable(phase))
    else $error("phase moved without a tick");

  a_dac_cmd: assert property (@(posedge clk) disable iff (rst)
    dac_valid |-> dac_word[15:12] == dds_pkg::DAC_CMD[15:12])
    else $error("DAC command bits corrupted");

endmodule

[sim/tb_dds_waveform_generator_core.sv]
`timescale 1ns / 100ps

module tb_dds_waveform_generator_core;
  import dds_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 100;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int MAX_PRINTED = 50;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam longint SAW_DEN = 20480000;
  localparam longint SAW_BASE_NUM = 2070 * SAW_DEN;
  localparam longint DC_DEN = 5000;
  localparam longint DC_POS_BASE = 10350000;
  localparam longint DC_NEG_BASE = 10345000;
  localparam longint DC_POS_GAIN = 1911;
  localparam longint DC_NEG_GAIN = 1907;
  localparam longint SAW_GAIN = 1911;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_TICK,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic [INDEX_WIDTH-1:0] addr;
    logic [WORD_WIDTH-1:0] word;
    logic [CFG_INDEX_WIDTH-1:0] reg_idx;
    logic [CFG_DATA_WIDTH-1:0] reg_val;
    bit checked;
    logic [WORD_WIDTH-1:0] dac_exp;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  logic op = 1'b0;
  logic [INDEX_WIDTH-1:0] table_index = '0;
  logic [WORD_WIDTH-1:0] table_word = '0;
  logic dac_valid;
  logic dac_ready = 1'b0;
  logic [WORD_WIDTH-1:0] dac_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

  dds_waveform_generator_core uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .op(op),
    .table_index(table_index),
    .table_word(table_word),
    .dac_valid(dac_valid),
    .dac_ready(dac_ready),
    .dac_word(dac_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the synthesizer state.
  logic [31:0] phase_q = '0;
  logic [31:0] tune_q = '0;
  logic [1:0] mode_q = MODE_TABLE;
  logic signed [AMP_WIDTH-1:0] amp_q = '0;
  logic [WORD_WIDTH-1:0] wave_mem [TABLE_DEPTH_DEF];
  bit written [TABLE_DEPTH_DEF];

  logic [WORD_WIDTH-1:0] expected_dac_words [$];
  plan_row_t directed_rows [$];

  int err_count = 0;
  int dac_checked = 0;
  int table_ticks = 0;
  int saw_ticks = 0;
  int dc_ticks = 0;
  int table_writes = 0;
  int reg_writes = 0;
  int items_sent = 0;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int stall_style = 0;
  int stall_left = 0;
  int rx_cycle = 0;
  int idle_cycles = 0;
  logic [WORD_WIDTH-1:0] dac_want;

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) != (d < 0))) q = q - 1;
    return q;
  endfunction

  function automatic logic [CODE_WIDTH-1:0] clamp_code(longint v);
    if (v < 0) return '0;
    if (v > 4095) return CODE_MAX;
    return v[CODE_WIDTH-1:0];
  endfunction

  task automatic predict_dac_word(output logic [WORD_WIDTH-1:0] word);
    logic [INDEX_WIDTH-1:0] ix;
    logic [CODE_WIDTH-1:0] code;
    longint pos;
    longint mv;
    longint num;
    phase_q = phase_q + tune_q;
    ix = phase_q[31:20];
    pos = ix;
    mv = amp_q;
    case (mode_q)
      MODE_SAW: begin
        num = SAW_BASE_NUM - SAW_GAIN * mv * pos;
        code = clamp_code(floor_quot(num, SAW_DEN));
        saw_ticks++;
      end
      MODE_DC: begin
        if (mv >= 0) num = DC_POS_BASE - DC_POS_GAIN * mv;
        else num = DC_NEG_BASE - DC_NEG_GAIN * mv;
        code = clamp_code(floor_quot(num, DC_DEN));
        dc_ticks++;
      end
      default: begin
        code = wave_mem[ix][CODE_WIDTH-1:0];
        table_ticks++;
      end
    endcase
    word = DAC_CMD | {4'h0, code};
  endtask

  task automatic report(string what, logic [WORD_WIDTH-1:0] got, logic [WORD_WIDTH-1:0] want);
    err_count++;
    if (err_count <= MAX_PRINTED)
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  task automatic send_item(input op_t kind, input logic [INDEX_WIDTH-1:0] a,
                           input logic [WORD_WIDTH-1:0] w, input bit checked,
                           input logic [WORD_WIDTH-1:0] dac_exp);
    logic [WORD_WIDTH-1:0] predicted;
    item_valid <= 1'b1;
    op <= kind;
    table_index <= a;
    table_word <= w;
    do @(posedge clk); while (item_ready !== 1'b1);
    items_sent++;
    if (kind == OP_WRITE) begin
      wave_mem[a] = w;
      written[a] = 1'b1;
      table_writes++;
    end else begin
      predict_dac_word(predicted);
      expected_dac_words.push_back(checked ? dac_exp : predicted);
    end
  endtask

  // A tick never lands on a table entry that has not been loaded yet.
  task automatic issue_tick(input bit checked, input logic [WORD_WIDTH-1:0] dac_exp);
    logic [31:0] next_phase;
    next_phase = phase_q + tune_q;
    if (!written[next_phase[31:20]])
      send_item(OP_WRITE, next_phase[31:20], 16'($urandom), 1'b0, '0);
    send_item(OP_TICK, 12'($urandom), 16'($urandom), checked, dac_exp);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_WIDTH-1:0] ri, input logic [CFG_DATA_WIDTH-1:0] rv);
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data <= rv;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (ri)
      CFG_TUNING: tune_q = rv;
      CFG_MODE: mode_q = rv[1:0];
      CFG_AMPLITUDE: amp_q = rv[AMP_WIDTH-1:0];
      default: ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (expected_dac_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
  endtask

  function automatic void plan_write(logic [INDEX_WIDTH-1:0] a, logic [WORD_WIDTH-1:0] w);
    plan_row_t r;
    r = '{kind: ROW_WRITE, addr: a, word: w, reg_idx: '0, reg_val: '0, checked: 1'b0, dac_exp: '0};
    directed_rows.push_back(r);
  endfunction

  function automatic void plan_tick(bit chk, logic [WORD_WIDTH-1:0] e);
    plan_row_t r;
    r = '{kind: ROW_TICK, addr: '0, word: '0, reg_idx: '0, reg_val: '0, checked: chk, dac_exp: e};
    directed_rows.push_back(r);
  endfunction

  function automatic void plan_cfg(logic [CFG_INDEX_WIDTH-1:0] ri, logic [CFG_DATA_WIDTH-1:0] rv);
    plan_row_t r;
    r = '{kind: ROW_CFG, addr: '0, word: '0, reg_idx: ri, reg_val: rv, checked: 1'b0, dac_exp: '0};
    directed_rows.push_back(r);
  endfunction

  always @(posedge clk) begin
    if (!rst && dac_valid === 1'b1 && dac_ready) begin
      if (expected_dac_words.size() == 0) begin
        report("dac_word with no tick pending", dac_word, '0);
      end else begin
        dac_want = expected_dac_words.pop_front();
        if (dac_word !== dac_want) report("dac_word", dac_word, dac_want);
        else dac_checked++;
      end
    end
    rx_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      dac_ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES - 1;
      dac_ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_style = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 120);
      end
      stall_left--;
      case (stall_style)
        0: dac_ready <= 1'b1;
        1: dac_ready <= ($urandom_range(0, 99) < 70);
        2: dac_ready <= ((rx_cycle % 4) != 3);
        default: dac_ready <= ($urandom_range(0, 99) < 25);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready === 1'b1) || (dac_valid === 1'b1 && dac_ready) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [31:0] tune;
    logic [1:0] mode;
    logic [CFG_DATA_WIDTH-1:0] amp_data;
    int phase_start;

    plan_write(12'd0, 16'hFFFF);
    plan_tick(1'b1, 16'h3FFF);
    plan_write(12'd0, 16'h0000);
    plan_tick(1'b1, 16'h3000);
    plan_write(12'd4095, 16'hA5A5);
    plan_cfg(CFG_TUNING, 32'hFFFF_FFFF);
    plan_tick(1'b1, 16'h35A5);
    plan_cfg(CFG_MODE, 32'(MODE_SAW));
    plan_cfg(CFG_AMPLITUDE, 32'd5000);
    plan_tick(1'b0, '0);
    plan_cfg(CFG_TUNING, 32'h8000_0000);
    plan_cfg(CFG_AMPLITUDE, 32'h0000_2000);
    plan_tick(1'b0, '0);
    plan_tick(1'b0, '0);
    plan_cfg(CFG_AMPLITUDE, 32'hFFFF_DFFF);
    plan_tick(1'b0, '0);
    plan_tick(1'b0, '0);
    plan_cfg(CFG_MODE, 32'(MODE_DC));
    plan_tick(1'b1, 16'h3000);
    plan_cfg(CFG_AMPLITUDE, 32'h0000_2000);
    plan_tick(1'b1, 16'h3FFF);
    plan_cfg(CFG_AMPLITUDE, 32'd0);
    plan_tick(1'b1, 16'h3816);
    plan_cfg(CFG_AMPLITUDE, 32'h0000_3FFF);
    plan_tick(1'b1, 16'h3815);
    plan_cfg(CFG_AMPLITUDE, 32'd5000);
    plan_tick(1'b1, 16'h309F);
    plan_cfg(CFG_AMPLITUDE, 32'h0000_2C78);
    plan_tick(1'b1, 16'h3F88);
    plan_cfg(CFG_MODE, 32'(MODE_UNUSED));
    plan_tick(1'b0, '0);
    plan_tick(1'b0, '0);
    plan_cfg(CFG_UNUSED, 32'hDEAD_BEEF);
    plan_tick(1'b0, '0);
    plan_cfg(CFG_MODE, 32'(MODE_TABLE));
    plan_cfg(CFG_TUNING, 32'h0010_0000);
    plan_tick(1'b0, '0);
    plan_tick(1'b0, '0);
    plan_tick(1'b0, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_WRITE: send_item(OP_WRITE, directed_rows[i].addr, directed_rows[i].word, 1'b0, '0);
        ROW_TICK: issue_tick(directed_rows[i].checked, directed_rows[i].dac_exp);
        default: begin
          wait_idle();
          cfg_write(directed_rows[i].reg_idx, directed_rows[i].reg_val);
        end
      endcase
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case ($urandom_range(0, 5))
        0: tune = '0;
        1: tune = 32'hFFFF_FFFF;
        2: tune = $urandom;
        3: tune = {12'($urandom), 20'h0};
        default: tune = $urandom_range(1, 32'h0040_0000);
      endcase
      mode = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 6))
        0: amp_data = 32'h0000_2000;
        1: amp_data = 32'h0000_1FFF;
        2: amp_data = 32'd5000;
        3: amp_data = 32'h0000_2C78;
        4: amp_data = 32'h0000_3FFF;
        default: amp_data = $urandom;
      endcase
      cfg_write(CFG_TUNING, tune);
      cfg_write(CFG_MODE, ($urandom & 32'hFFFF_FFFC) | 32'(mode));
      cfg_write(CFG_AMPLITUDE, amp_data);
      if (ph % 3 == 2) cfg_write(CFG_UNUSED, $urandom);
      no_gaps = (ph == 3);
      burst_left = 0;
      phase_start = items_sent;
      for (int n = 0; items_sent - phase_start < ITEMS_PER_PHASE; n++) begin
        if (ph == 1 && n == 20) begin
          hold_req <= hold_req + 1;
          burst_left = 60;
        end else begin
          pace();
        end
        if ($urandom_range(0, 99) < 25)
          send_item(OP_WRITE, 12'($urandom), 16'($urandom), 1'b0, '0);
        else
          issue_tick(1'b0, '0);
      end
    end

    wait_idle();
    repeat (12) @(posedge clk);
    $display("Checked %0d DAC words: %0d table, %0d sawtooth, %0d dc ticks.",
             dac_checked, table_ticks, saw_ticks, dc_ticks);
    $display("Loaded %0d table entries and made %0d register writes across %0d settings.",
             table_writes, reg_writes, PHASES + 1);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/dds_pkg.sv
hw/rtl/dds_ram.sv
hw/rtl/dds_ctrl.sv
hw/rtl/dds_code.sv
hw/rtl/dds_waveform_generator_core.sv
sim/tb_dds_waveform_generator_core.sv
